// File: rtl/core/lcgrd_pkg.sv
// Package for the LCG random draw unit: action codes, generator constants,
// the micro-instruction format and the microcode and entry-point tables.
// No dependencies.
package lcgrd_pkg;

  // Action codes carried by the input item.
  localparam logic [2:0] ActSeed   = 3'd0;
  localparam logic [2:0] ActRand8  = 3'd1;
  localparam logic [2:0] ActBelow8 = 3'd2;
  localparam logic [2:0] ActRand16 = 3'd3;
  localparam logic [2:0] ActBelow16 = 3'd4;
  localparam logic [2:0] ActWheel  = 3'd5;

  // Generator constants.
  localparam logic [15:0] LcgMul       = 16'd2053;
  localparam logic [15:0] LcgAdd       = 16'd13849;
  localparam logic [7:0]  ByteMask     = 8'hFF;
  localparam logic [7:0]  WheelMinDist = 8'd42;

  // Micro-program counter width and the last address in use.
  localparam int unsigned PcW = 4;
  localparam logic [PcW-1:0] PcLast = 4'd14;

  // Entry points of the micro-program.
  localparam logic [PcW-1:0] UpSeed   = 4'd0;
  localparam logic [PcW-1:0] UpBad    = 4'd1;
  localparam logic [PcW-1:0] UpRand8  = 4'd2;
  localparam logic [PcW-1:0] UpBelow8 = 4'd4;
  localparam logic [PcW-1:0] UpRand16 = 4'd6;
  localparam logic [PcW-1:0] UpBelow16 = 4'd9;
  localparam logic [PcW-1:0] UpWheel  = 4'd13;

  // What a step writes into the result register.
  typedef enum logic [2:0] {
    RsNone,
    RsZero,
    RsByte,
    RsShiftByte,
    RsScale8,
    RsScale16,
    RsSeed
  } rsel_e;

  typedef struct packed {
    logic           adv;    // advance the generator, capture its byte
    rsel_e          rsel;
    logic           jnear;  // jump to tgt when the byte is too near the wheel position
    logic [PcW-1:0] tgt;
    logic           last;   // item completes here unless the jump is taken
  } ucw_t;

  function automatic ucw_t ucw(input logic adv, input rsel_e rsel, input logic jnear,
                               input logic [PcW-1:0] tgt, input logic last);
    ucw_t w;
    w.adv   = adv;
    w.rsel  = rsel;
    w.jnear = jnear;
    w.tgt   = tgt;
    w.last  = last;
    return w;
  endfunction

  function automatic ucw_t ucode_rom(input logic [PcW-1:0] addr);
    ucw_t w;
    unique case (addr)
      4'd0:    w = ucw(1'b0, RsSeed,      1'b0, '0, 1'b1);
      4'd1:    w = ucw(1'b0, RsZero,      1'b0, '0, 1'b1);
      4'd2:    w = ucw(1'b1, RsNone,      1'b0, '0, 1'b0);
      4'd3:    w = ucw(1'b0, RsByte,      1'b0, '0, 1'b1);
      4'd4:    w = ucw(1'b1, RsNone,      1'b0, '0, 1'b0);
      4'd5:    w = ucw(1'b0, RsScale8,    1'b0, '0, 1'b1);
      4'd6:    w = ucw(1'b1, RsNone,      1'b0, '0, 1'b0);
      4'd7:    w = ucw(1'b1, RsByte,      1'b0, '0, 1'b0);
      4'd8:    w = ucw(1'b0, RsShiftByte, 1'b0, '0, 1'b1);
      4'd9:    w = ucw(1'b1, RsNone,      1'b0, '0, 1'b0);
      4'd10:   w = ucw(1'b1, RsByte,      1'b0, '0, 1'b0);
      4'd11:   w = ucw(1'b0, RsShiftByte, 1'b0, '0, 1'b0);
      4'd12:   w = ucw(1'b0, RsScale16,   1'b0, '0, 1'b1);
      4'd13:   w = ucw(1'b1, RsNone,      1'b0, '0, 1'b0);
      4'd14:   w = ucw(1'b0, RsByte,      1'b1, UpWheel, 1'b1);
      default: w = ucw(1'b0, RsZero,      1'b0, '0, 1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [PcW-1:0] entry_point(input logic [2:0] action);
    logic [PcW-1:0] a;
    unique case (action)
      ActSeed:    a = UpSeed;
      ActRand8:   a = UpRand8;
      ActBelow8:  a = UpBelow8;
      ActRand16:  a = UpRand16;
      ActBelow16: a = UpBelow16;
      ActWheel:   a = UpWheel;
      default:    a = UpBad;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/lcg_random_draw_unit.sv
// Top level of the LCG random draw unit: micro-sequencer and datapath.
// Depends on lcgrd_pkg.
//
// Usage: an item on the input channel (in_valid_i/in_ready_o) selects an action:
// load a seed, a raw byte, a byte scaled below limit_i[7:0], a 16-bit draw built
// from two bytes, a 16-bit draw scaled below limit_i, or a wheel index at least 42
// steps (circularly) away from wheel_position_i. Each item yields exactly one
// result on draw_o (out_valid_o/out_ready_o); a seed load returns 0.
// After the accepting edge the micro-program runs its routine: a seed load or an
// unused action code completes on its entry step; a byte draw advances the
// generator, then returns the byte or its scaled form; a 16-bit draw advances
// twice and joins the two bytes, and the scaled one then scales that word; a
// wheel index advances and tests the byte, trying until a byte lands far enough
// away. One item is in work at a time; the next item is taken once the current
// one has moved into the output register, so a result may wait there while the
// next item runs. If the output is still full when an item completes, the
// sequencer holds on its last step until the receiver takes it. Reset clears the
// generator word to zero, empties the output and idles the sequencer.
module lcg_random_draw_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] seed_value_i,
  input  logic [15:0] limit_i,
  input  logic [7:0]  wheel_position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] draw_o
);
  import lcgrd_pkg::*;

  logic            busy_q, busy_d;
  logic [PcW-1:0]  pc_q, pc_d;
  logic [15:0]     gw_q, gw_d;
  logic [7:0]      byte_q, byte_d;
  logic [15:0]     res_q, res_d;
  logic [15:0]     seed_q, lim_q;
  logic [7:0]      pos_q;
  logic            out_valid_q, out_valid_d;
  logic [15:0]     out_q, out_d;

  ucw_t            cw;
  logic            in_acc, jump, finish, stall;
  logic [15:0]     gw_nxt, byte_sum;
  logic [15:0]     prod8;
  logic [31:0]     prod16;
  logic [7:0]      dx, dy, circ_dist;
  logic            near;

  assign cw         = ucode_rom(pc_q);
  assign in_ready_o = ~busy_q;
  assign in_acc     = in_valid_i & in_ready_o;

  // Generator step and its byte.
  assign gw_nxt   = gw_q * LcgMul + LcgAdd;
  assign byte_sum = gw_nxt + {8'd0, gw_nxt[15:8]};

  // Circular distance of the captured byte from the wheel position.
  assign dx        = (pos_q >= byte_q) ? (pos_q - byte_q) : (byte_q - pos_q);
  assign dy        = ByteMask - dx;
  assign circ_dist = (dx < dy) ? dx : dy;
  assign near      = circ_dist < WheelMinDist;

  assign prod8  = byte_q * lim_q[7:0];
  assign prod16 = res_q * lim_q;

  assign jump   = busy_q & cw.jnear & near;
  assign finish = busy_q & cw.last & ~jump;
  assign stall  = finish & out_valid_q & ~out_ready_i;

  always_comb begin
    case (cw.rsel)
      RsZero:      res_d = '0;
      RsSeed:      res_d = '0;
      RsByte:      res_d = {8'd0, byte_q};
      RsShiftByte: res_d = {res_q[7:0], byte_q};
      RsScale8:    res_d = {8'd0, prod8[15:8]};
      RsScale16:   res_d = prod16[31:16];
      default:     res_d = res_q;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    gw_d        = gw_q;
    byte_d      = byte_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    if (in_acc) begin
      busy_d = 1'b1;
      pc_d   = entry_point(action_i);
    end else if (busy_q && !stall) begin
      if (cw.adv) begin
        gw_d   = gw_nxt;
        byte_d = byte_sum[7:0];
      end
      if (cw.rsel == RsSeed) begin
        gw_d = seed_q;
      end
      if (jump) begin
        pc_d = cw.tgt;
      end else begin
        pc_d = pc_q + 1'b1;
      end
      if (finish) begin
        busy_d      = 1'b0;
        out_valid_d = 1'b1;
        out_d       = res_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      gw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      gw_q        <= gw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    out_q  <= out_d;
    if (in_acc) begin
      seed_q <= seed_value_i;
      lim_q  <= limit_i;
      pos_q  <= wheel_position_i;
    end
    if (busy_q && !stall && !in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign draw_o      = out_q;

  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && (pc_q == entry_point($past(action_i))))
    else $error("sequencer did not start at the action's entry point");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= PcLast))
    else $error("micro-program counter left the program");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> busy_q && $stable(gw_q) && $stable(pc_q))
    else $error("item completed while the output register was still full");

  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && !stall) |=> out_valid_q && !busy_q)
    else $error("completed item did not reach the output register");

endmodule

// File: tb/lcg_draw_tb_pkg.sv
// Scoreboard for the LCG random draw unit testbench: it keeps its own copy of
// the generator word, predicts the draw of every accepted item and checks results.
// Depends on lcgrd_pkg for the action codes.
package lcg_draw_tb_pkg;

  import lcgrd_pkg::*;

  // The two action codes that the block treats as no-operations.
  localparam logic [2:0] ActSpareA = 3'd6;
  localparam logic [2:0] ActSpareB = 3'd7;

  localparam logic [31:0] LcgMultiplier = 32'd2053;
  localparam logic [31:0] LcgIncrement  = 32'd13849;
  localparam logic [7:0]  WheelGap      = 8'd42;
  localparam int unsigned WheelTryLimit = 65536;
  localparam int unsigned ReportLines   = 40;

  typedef struct {
    int unsigned item_no;
    logic [2:0]  action;
    logic [15:0] draw;
  } draw_expect_t;

  class draw_scoreboard;
    logic [15:0]  gen_word;
    draw_expect_t expected_draws[$];
    int unsigned  items_seen;
    int unsigned  mismatches;

    function new();
      gen_word   = '0;
      items_seen = 0;
      mismatches = 0;
    endfunction

    function logic [7:0] next_byte();
      logic [31:0] w;
      w = 32'(gen_word) * LcgMultiplier + LcgIncrement;
      gen_word = w[15:0];
      return gen_word[7:0] + gen_word[15:8];
    endfunction

    function logic [15:0] next_word();
      logic [7:0] hi;
      logic [7:0] lo;
      hi = next_byte();
      lo = next_byte();
      return {hi, lo};
    endfunction

    function logic [15:0] predict_draw(logic [2:0] act, logic [15:0] seed,
                                       logic [15:0] lim, logic [7:0] pos);
      logic [15:0] result;
      logic [31:0] prod;
      logic [7:0]  r;
      logic [7:0]  x;
      logic [7:0]  circ_dist;
      int unsigned tries;
      bit          done;
      result = '0;
      case (act)
        ActSeed: begin
          gen_word = seed;
        end
        ActRand8: begin
          result = {8'h00, next_byte()};
        end
        ActBelow8: begin
          prod   = 32'(next_byte()) * 32'(lim[7:0]);
          result = {8'h00, prod[15:8]};
        end
        ActRand16: begin
          result = next_word();
        end
        ActBelow16: begin
          prod   = 32'(next_word()) * 32'(lim);
          result = prod[31:16];
        end
        ActWheel: begin
          // Keep drawing until the byte is far enough round the wheel.
          tries = 0;
          done  = 1'b0;
          r     = '0;
          while (!done && tries < WheelTryLimit) begin
            r         = next_byte();
            x         = (pos >= r) ? pos - r : r - pos;
            circ_dist = (x < 8'd255 - x) ? x : 8'd255 - x;
            done      = (circ_dist >= WheelGap);
            tries++;
          end
          result = {8'h00, r};
        end
        default: begin
          result = '0;
        end
      endcase
      return result;
    endfunction

    function void note_item(logic [2:0] act, logic [15:0] seed, logic [15:0] lim,
                            logic [7:0] pos);
      draw_expect_t e;
      e.item_no = items_seen;
      e.action  = act;
      e.draw    = predict_draw(act, seed, lim, pos);
      expected_draws.push_back(e);
      items_seen++;
    endfunction

    function int unsigned pending();
      return expected_draws.size();
    endfunction

    task report_mismatch(string what);
      if (mismatches < ReportLines) $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_draw(logic [15:0] got);
      draw_expect_t e;
      if (expected_draws.size() == 0) begin
        report_mismatch($sformatf("draw %h arrived with no item outstanding", got));
      end else begin
        e = expected_draws.pop_front();
        if (got !== e.draw)
          report_mismatch($sformatf("item %0d action %0d: draw %h, predicted %h",
                                    e.item_no, e.action, got, e.draw));
      end
    endtask

    task check_leftovers();
      draw_expect_t e;
      while (expected_draws.size() != 0) begin
        e = expected_draws.pop_front();
        report_mismatch($sformatf("item %0d action %0d: no draw returned",
                                  e.item_no, e.action));
      end
    endtask
  endclass

endpackage

// File: tb/tb_lcg_random_draw_unit.sv
// Top of the testbench for the LCG random draw unit: clock, reset, item driver,
// result sink and stimulus, with directed items first and random items after.
// Depends on lcgrd_pkg, lcg_draw_tb_pkg and the lcg_random_draw_unit RTL.
module tb_lcg_random_draw_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import lcgrd_pkg::*;
  import lcg_draw_tb_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned MaxIdle     = 17;
  localparam int unsigned DrainCycles = 20;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic [2:0]  action_i         = ActSeed;
  logic [15:0] seed_value_i     = '0;
  logic [15:0] limit_i          = '0;
  logic [7:0]  wheel_position_i = '0;
  logic        out_ready_i      = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [15:0] draw_o;

  bit          quiet_phase = 1'b0;  // neither side idles while this is set
  int unsigned cycles      = 0;

  draw_scoreboard sb = new();

  lcg_random_draw_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .seed_value_i     (seed_value_i),
    .limit_i          (limit_i),
    .wheel_position_i (wheel_position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .draw_o           (draw_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_draw(draw_o);
  end

  // Result sink: a random stall before each result is taken.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, MaxIdle);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o && out_ready_i));
    end
  end

  // Valid is left high after an item is taken, so that a back-to-back item
  // only changes the payload.
  task automatic send_item(input logic [2:0] act, input logic [15:0] seed,
                           input logic [15:0] lim, input logic [7:0] pos);
    int unsigned gap;
    gap = quiet_phase ? 0 : $urandom_range(0, MaxIdle);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    seed_value_i     <= seed;
    limit_i          <= lim;
    wheel_position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(act, seed, lim, pos);
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [2:0]  act;
    logic [15:0] seed;
    logic [15:0] lim;
    int unsigned pick;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items; the first one draws from the zero word left by reset.
    send_item(ActRand8,   16'h1234, 16'h0000, 8'h00);
    send_item(ActSeed,    16'hFFFF, 16'h0000, 8'h00);
    send_item(ActRand8,   16'h0000, 16'hFFFF, 8'hFF);
    send_item(ActBelow8,  16'h0000, 16'h0000, 8'h00);
    send_item(ActBelow8,  16'h0000, 16'h00FF, 8'h00);
    send_item(ActBelow8,  16'h0000, 16'hFF00, 8'h00);
    send_item(ActBelow8,  16'h0000, 16'hFFFF, 8'h00);
    send_item(ActRand16,  16'h0000, 16'h0000, 8'h00);
    send_item(ActBelow16, 16'h0000, 16'h0000, 8'h00);
    send_item(ActBelow16, 16'h0000, 16'hFFFF, 8'h00);
    send_item(ActBelow16, 16'h0000, 16'h0001, 8'h00);
    send_item(ActWheel,   16'h0000, 16'h0000, 8'h00);
    send_item(ActWheel,   16'h0000, 16'h0000, 8'hFF);
    send_item(ActWheel,   16'h0000, 16'h0000, 8'h80);
    send_item(ActWheel,   16'h0000, 16'h0000, 8'h7F);
    send_item(ActSpareA,  16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(ActSpareB,  16'hA5A5, 16'h5A5A, 8'h2A);
    send_item(ActRand8,   16'h0000, 16'h0000, 8'h00);
    send_item(ActSeed,    16'h0000, 16'hFFFF, 8'hFF);
    send_item(ActRand16,  16'h0000, 16'h0000, 8'h00);
    send_item(ActSeed,    16'h8000, 16'h0000, 8'h00);
    send_item(ActWheel,   16'h0000, 16'h0000, 8'h2A);
    send_item(ActBelow16, 16'h0000, 16'h8000, 8'h00);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      // Every third block of a hundred items runs with no idling at all.
      if (i % 100 == 0) quiet_phase = ((i / 100) % 3 == 1);
      if (i == RandomItems / 2) wait_until_drained();
      pick = $urandom_range(0, 99);
      if (pick < 6)       act = ActSeed;
      else if (pick < 8)  act = ActSpareA;
      else if (pick < 10) act = ActSpareB;
      else                act = 3'($urandom_range(ActRand8, ActWheel));
      seed = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 9);
      if (pick == 0)      lim = 16'h0000;
      else if (pick == 1) lim = 16'hFFFF;
      else                lim = 16'($urandom_range(0, 65535));
      send_item(act, seed, lim, 8'($urandom_range(0, 255)));
    end

    quiet_phase = 1'b0;
    wait_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    sb.check_leftovers();
    if (sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lcgrd_pkg.sv
rtl/core/lcg_random_draw_unit.sv
tb/lcg_draw_tb_pkg.sv
tb/tb_lcg_random_draw_unit.sv
